[src/tsfn_pkg.sv]
// ----------------------------------------------------------------------------
// tsfn_pkg
// Shared types, constants and the quarter-wave sine table builder for the
// two-tone sine generator with filtered noise.
// ----------------------------------------------------------------------------
package tsfn_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_OUT_BITS   = 16;

  localparam int QUARTER_LEN = 1 << SINE_TABLE_BITS;
  localparam int TABLE_LEN   = QUARTER_LEN + 1;
  localparam int ROM_ADDR_W  = SINE_TABLE_BITS + 1;
  localparam int SINE_MAG_W  = SINE_OUT_BITS - 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0] LFSR_TAPS   = 32'h8020_0003;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 35;

  localparam int NUM_STEPS  = 9;
  localparam int STEP_W     = $clog2(NUM_STEPS);
  localparam int STEP_IDLE  = 0;
  localparam int STEP_HELD  = 7;
  localparam int STEP_LAST  = 8;

  typedef enum logic [2:0] {
    REG_ALPHA_AMPLITUDE = 3'd0,
    REG_ALPHA_FREQUENCY = 3'd1,
    REG_BETA_AMPLITUDE  = 3'd2,
    REG_BETA_FREQUENCY  = 3'd3,
    REG_NOISE_GAIN      = 3'd4,
    REG_NOISE_KEEP      = 3'd5,
    REG_NOISE_SEED      = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FREQ_A,
    MUL_FREQ_B,
    MUL_TONE_A,
    MUL_TONE_B,
    MUL_WHITE,
    MUL_KEEP
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_TONE_FIRST,
    ACC_TONE_ADD,
    ACC_WHITE,
    ACC_HELD,
    ACC_OUT
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jump_t;

  typedef struct packed {
    mul_sel_t mul;
    logic     phase;
    acc_op_t  acc;
    jump_t    jump;
  } ucode_t;

  // The microprogram: one control word per step.
  localparam ucode_t UCODE [NUM_STEPS] = '{
    '{MUL_NONE,   1'b0, ACC_NONE,       JMP_WAIT_IN},
    '{MUL_FREQ_A, 1'b0, ACC_NONE,       JMP_NEXT},
    '{MUL_FREQ_B, 1'b1, ACC_NONE,       JMP_NEXT},
    '{MUL_TONE_A, 1'b1, ACC_NONE,       JMP_NEXT},
    '{MUL_TONE_B, 1'b0, ACC_TONE_FIRST, JMP_NEXT},
    '{MUL_WHITE,  1'b0, ACC_TONE_ADD,   JMP_NEXT},
    '{MUL_KEEP,   1'b0, ACC_WHITE,      JMP_NEXT},
    '{MUL_NONE,   1'b0, ACC_HELD,       JMP_NEXT},
    '{MUL_NONE,   1'b0, ACC_OUT,        JMP_WAIT_OUT}
  };

  typedef logic [SINE_MAG_W-1:0] sine_rom_t [TABLE_LEN];

  // Quarter-wave sine in Q30 by a truncated Taylor series, rounded to the
  // output format. Evaluated at elaboration only.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    localparam int SH = 30 - SINE_MAG_W;
    localparam logic signed [63:0] TOP = (64'sd1 <<< SINE_MAG_W) - 64'sd1;
    for (int i = 0; i < TABLE_LEN; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd272;
      sum  = sum + $signed(term);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = (sum + (64'sd1 <<< (SH - 1))) >>> SH;
      if (v > TOP) begin
        v = TOP;
      end
      rom[i] = v[SINE_MAG_W-1:0];
    end
    return rom;
  endfunction

endpackage

[src/two_tone_sine_with_filtered_noise.sv]
// ----------------------------------------------------------------------------
// two_tone_sine_with_filtered_noise
// Sum of two table-driven sine tones and first-order filtered LFSR noise,
// computed by a microcoded sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
//  Channel   Ports                              Moves
//  input     in_valid, in_stall, in_time_stamp  one time stamp per request
//  result    out_valid, out_stall,              one sample per request
//            out_sample_value
//  config    psel, penable, pwrite, paddr,      register writes and reads
//            pwdata, prdata, pready
//
// A sample is built step by step between acceptance and the output register:
// six products pass one by one through the single multiplier, and the sine
// table read adds a registered stage. An input can be accepted in the cycle
// after the previous result is loaded, and not before, so samples do not
// overlap. Reset is synchronous and needs no clearing pass. A result waiting
// under out_stall holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module two_tone_sine_with_filtered_noise (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_time_stamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_sample_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PROD_W  = tsfn_pkg::PROD_W;
  localparam int ACC_W   = tsfn_pkg::ACC_W;
  localparam int A_W     = tsfn_pkg::MUL_A_W;
  localparam int B_W     = tsfn_pkg::MUL_B_W;
  localparam int SOB     = tsfn_pkg::SINE_OUT_BITS;
  localparam int STB     = tsfn_pkg::SINE_TABLE_BITS;
  localparam int AW      = tsfn_pkg::ROM_ADDR_W;
  localparam int TONE_SH = SOB - 1;

  localparam tsfn_pkg::sine_rom_t SINE_ROM = tsfn_pkg::build_sine_rom();

  localparam logic signed [PROD_W-1:0] TONE_HALF  = PROD_W'(1) << (TONE_SH - 1);
  localparam logic signed [PROD_W-1:0] WHITE_HALF = PROD_W'(1) << 14;
  localparam logic signed [PROD_W-1:0] KEEP_HALF  = PROD_W'(1) << 15;
  localparam logic signed [ACC_W-1:0]  MAX32      = ACC_W'(32'h7fff_ffff);
  localparam logic signed [ACC_W-1:0]  MIN32      = -MAX32 - ACC_W'(1);
  localparam logic [16:0]              KEEP_ONE   = 17'd65536;

  logic signed [15:0] alpha_amp_r;
  logic [15:0]        alpha_freq_r;
  logic signed [15:0] beta_amp_r;
  logic [15:0]        beta_freq_r;
  logic [15:0]        noise_gain_r;
  logic [16:0]        noise_keep_r;
  logic [31:0]        noise_seed_r;

  logic [tsfn_pkg::STEP_W-1:0] step_r, step_nxt;
  tsfn_pkg::ucode_t            uc;

  logic [31:0]              t_r;
  logic [31:0]              lfsr_r, lfsr_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [A_W-1:0]    mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic [tsfn_pkg::SINE_MAG_W-1:0] rom_q_r;
  logic                     neg_r;
  logic signed [SOB-1:0]    sine_s;
  logic [23:0]              frac;
  logic [STB-1:0]           tab_j;
  logic [AW-1:0]            rom_addr;

  logic signed [PROD_W-1:0] tone_full, white_full, kept_full;
  logic signed [ACC_W-1:0]  tone_rnd, white_rnd, kept_rnd;
  logic signed [ACC_W-1:0]  acc_r, white_r;
  logic signed [31:0]       held_r;
  logic signed [ACC_W-1:0]  held_sum, out_sum;
  logic [31:0]              out_r;
  logic                     out_valid_r;

  logic in_acc, out_free, cfg_wr;

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > MAX32) begin
      return 32'h7fff_ffff;
    end else if (v < MIN32) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_amp_r  <= 16'sd2560;
      alpha_freq_r <= 16'd2560;
      beta_amp_r   <= 16'sd1280;
      beta_freq_r  <= 16'd5120;
      noise_gain_r <= 16'd512;
      noise_keep_r <= 17'd58982;
      noise_seed_r <= 32'd1;
    end else if (cfg_wr) begin
      case (tsfn_pkg::reg_idx_t'(paddr[4:2]))
        tsfn_pkg::REG_ALPHA_AMPLITUDE: alpha_amp_r  <= pwdata[15:0];
        tsfn_pkg::REG_ALPHA_FREQUENCY: alpha_freq_r <= pwdata[15:0];
        tsfn_pkg::REG_BETA_AMPLITUDE:  beta_amp_r   <= pwdata[15:0];
        tsfn_pkg::REG_BETA_FREQUENCY:  beta_freq_r  <= pwdata[15:0];
        tsfn_pkg::REG_NOISE_GAIN:      noise_gain_r <= pwdata[15:0];
        tsfn_pkg::REG_NOISE_KEEP: begin
          noise_keep_r <= (pwdata[16:0] > KEEP_ONE) ? KEEP_ONE : pwdata[16:0];
        end
        tsfn_pkg::REG_NOISE_SEED:      noise_seed_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (tsfn_pkg::reg_idx_t'(paddr[4:2]))
      tsfn_pkg::REG_ALPHA_AMPLITUDE: prdata = {16'd0, alpha_amp_r};
      tsfn_pkg::REG_ALPHA_FREQUENCY: prdata = {16'd0, alpha_freq_r};
      tsfn_pkg::REG_BETA_AMPLITUDE:  prdata = {16'd0, beta_amp_r};
      tsfn_pkg::REG_BETA_FREQUENCY:  prdata = {16'd0, beta_freq_r};
      tsfn_pkg::REG_NOISE_GAIN:      prdata = {16'd0, noise_gain_r};
      tsfn_pkg::REG_NOISE_KEEP:      prdata = {15'd0, noise_keep_r};
      tsfn_pkg::REG_NOISE_SEED:      prdata = noise_seed_r;
      default:                       prdata = 32'd0;
    endcase
  end

  // Sequencer.
  assign uc       = tsfn_pkg::UCODE[step_r];
  assign in_stall = (step_r != tsfn_pkg::STEP_W'(tsfn_pkg::STEP_IDLE));
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (uc.jump)
      tsfn_pkg::JMP_NEXT:     step_nxt = step_r + tsfn_pkg::STEP_W'(1);
      tsfn_pkg::JMP_WAIT_IN:  step_nxt = in_acc ? step_r + tsfn_pkg::STEP_W'(1) : step_r;
      tsfn_pkg::JMP_WAIT_OUT: step_nxt = out_free ?
                                         tsfn_pkg::STEP_W'(tsfn_pkg::STEP_IDLE) : step_r;
      default:                step_nxt = tsfn_pkg::STEP_W'(tsfn_pkg::STEP_IDLE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tsfn_pkg::STEP_W'(tsfn_pkg::STEP_IDLE);
    end else begin
      step_r <= step_nxt;
    end
  end

  // Noise generator.
  assign lfsr_nxt = {1'b0, lfsr_r[31:1]} ^ (lfsr_r[0] ? tsfn_pkg::LFSR_TAPS : 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= 32'd1;
    end else if (cfg_wr && (tsfn_pkg::reg_idx_t'(paddr[4:2]) == tsfn_pkg::REG_NOISE_SEED)) begin
      lfsr_r <= (pwdata == 32'd0) ? 32'd1 : pwdata;
    end else if (in_acc) begin
      lfsr_r <= lfsr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_r <= in_time_stamp;
    end
  end

  // Phase to table address, with quadrant mirroring.
  assign frac     = prod_r[23:0];
  assign tab_j    = frac[21 -: STB];
  assign rom_addr = frac[22] ? (AW'(tsfn_pkg::QUARTER_LEN) - {1'b0, tab_j}) : {1'b0, tab_j};

  always_ff @(posedge clk) begin
    if (uc.phase) begin
      rom_q_r <= SINE_ROM[rom_addr];
      neg_r   <= frac[23];
    end
  end

  assign sine_s = neg_r ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});

  // Shared multiplier.
  always_comb begin
    case (uc.mul)
      tsfn_pkg::MUL_FREQ_A: begin
        mul_a = {1'b0, t_r};
        mul_b = {2'b00, alpha_freq_r};
      end
      tsfn_pkg::MUL_FREQ_B: begin
        mul_a = {1'b0, t_r};
        mul_b = {2'b00, beta_freq_r};
      end
      tsfn_pkg::MUL_TONE_A: begin
        mul_a = {{(A_W-SOB){sine_s[SOB-1]}}, sine_s};
        mul_b = {{2{alpha_amp_r[15]}}, alpha_amp_r};
      end
      tsfn_pkg::MUL_TONE_B: begin
        mul_a = {{(A_W-SOB){sine_s[SOB-1]}}, sine_s};
        mul_b = {{2{beta_amp_r[15]}}, beta_amp_r};
      end
      tsfn_pkg::MUL_WHITE: begin
        mul_a = {{(A_W-16){lfsr_r[31]}}, lfsr_r[31:16]};
        mul_b = {2'b00, noise_gain_r};
      end
      tsfn_pkg::MUL_KEEP: begin
        mul_a = {held_r[31], held_r};
        mul_b = {1'b0, noise_keep_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Rounding half up of the registered product.
  assign tone_full  = (prod_r + TONE_HALF) >>> TONE_SH;
  assign white_full = (prod_r + WHITE_HALF) >>> 15;
  assign kept_full  = (prod_r + KEEP_HALF) >>> 16;
  assign tone_rnd   = tone_full[ACC_W-1:0];
  assign white_rnd  = white_full[ACC_W-1:0];
  assign kept_rnd   = kept_full[ACC_W-1:0];

  assign held_sum = kept_rnd + white_r;
  assign out_sum  = acc_r + {{(ACC_W-32){held_r[31]}}, held_r};

  always_ff @(posedge clk) begin
    case (uc.acc)
      tsfn_pkg::ACC_TONE_FIRST: acc_r   <= tone_rnd;
      tsfn_pkg::ACC_TONE_ADD:   acc_r   <= acc_r + tone_rnd;
      tsfn_pkg::ACC_WHITE:      white_r <= white_rnd;
      tsfn_pkg::ACC_OUT: begin
        if (out_free) begin
          out_r <= sat32(out_sum);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 32'sd0;
      out_valid_r <= 1'b0;
    end else begin
      if (uc.acc == tsfn_pkg::ACC_HELD) begin
        held_r <= sat32(held_sum);
      end
      if ((uc.acc == tsfn_pkg::ACC_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_r;

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != 32'd0)
    else $error("noise LFSR reached the all-zero state");

  a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < tsfn_pkg::STEP_W'(tsfn_pkg::NUM_STEPS))
    else $error("step counter left the microprogram");

  a_held_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != tsfn_pkg::STEP_W'(tsfn_pkg::STEP_HELD)) |=> $stable(held_r))
    else $error("held noise changed outside its update step");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(step_r) == tsfn_pkg::STEP_W'(tsfn_pkg::STEP_LAST)))
    else $error("result loaded outside the final step");

endmodule
